FILE: src/sbhp_pkg.sv
// ----------------------------------------------------------------------------
// sbhp_pkg
// Shared types and constants for the subtitle bitmap header parser.
// ----------------------------------------------------------------------------
package sbhp_pkg;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] NIBBLE_LO_MASK = 8'h0F;

  // record sections
  typedef enum logic [2:0] {
    SEC_MAIN    = 3'd0,
    SEC_FRAME   = 3'd1,
    SEC_OUTLINE = 3'd2,
    SEC_SHADOW  = 3'd3,
    SEC_SKIP    = 3'd4,
    SEC_LENGTH  = 3'd5,
    SEC_PAYLOAD = 3'd6
  } sec_t;

  // outline style codes in the style byte
  typedef enum logic [1:0] {
    OL_NONE     = 2'd0,
    OL_OUTLINE  = 2'd1,
    OL_SHADOW   = 2'd2,
    OL_RESERVED = 2'd3
  } outline_t;

  // tag carried with each emitted field
  typedef enum logic [4:0] {
    K_STYLES         = 5'd0,
    K_CHAR_COLOUR    = 5'd1,
    K_CHAR_TOP_X     = 5'd2,
    K_CHAR_TOP_Y     = 5'd3,
    K_CHAR_BOT_X     = 5'd4,
    K_CHAR_BOT_Y     = 5'd5,
    K_FRAME_TOP_X    = 5'd6,
    K_FRAME_TOP_Y    = 5'd7,
    K_FRAME_BOT_X    = 5'd8,
    K_FRAME_BOT_Y    = 5'd9,
    K_FRAME_COLOUR   = 5'd10,
    K_OUTLINE_THICK  = 5'd11,
    K_OUTLINE_COLOUR = 5'd12,
    K_SHADOW_OFFSETS = 5'd13,
    K_SHADOW_COLOUR  = 5'd14,
    K_LENGTH         = 5'd15,
    K_PAYLOAD        = 5'd16,
    K_TRUNC          = 5'd17
  } kind_t;

  // classified byte handed from the front end to the back end
  typedef struct packed {
    kind_t      kind;
    logic [7:0] held;
    logic [7:0] data;
    logic       done;
  } entry_t;

endpackage

FILE: src/subtitle_bitmap_header_parser.sv
// ----------------------------------------------------------------------------
// subtitle_bitmap_header_parser
// Parses a subtitle simple-bitmap record byte by byte and emits each header
// field, the bitmap length and every payload byte as a tagged beat.
// ----------------------------------------------------------------------------
// Input stream: one record byte per beat in s_tdata, s_tuser high on the first
// byte of a record, s_tlast high on the final byte the record holds.
// Output stream: one beat per completed field; m_tdata carries the field tag
// and value, m_tlast marks the last beat of the record and m_tuser marks a
// truncated record (tag 17, value 0).
// Throughput: one byte per cycle while the queue has room. The parser
// classifies a byte in the cycle it is accepted and drops the result into a
// four-entry queue; the output stage builds the value from the queued bytes
// and registers it, so a result beat passes through the queue and then the
// output register before it is presented on m_tvalid.
// When the receiver stalls, the queue absorbs up to four results; s_tready
// falls only when the queue is full, and bytes that produce no result still
// need a free queue slot to be taken.
// Reset: synchronous; no record is active afterwards, so bytes are ignored
// until one arrives with s_tuser high. The queue and output register empty.
// ----------------------------------------------------------------------------
module subtitle_bitmap_header_parser import sbhp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // record_start
  input  logic        s_tlast,   // record_last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [4:0] field_kind, [20:5] field_value, [23:21] zero
  output logic        m_tuser,   // truncated_error
  output logic        m_tlast    // record_done
);

  logic        push;
  entry_t      push_entry;
  entry_t      head;
  logic        empty;
  logic        full;
  logic        pop;
  kind_t       out_kind;
  logic [15:0] out_value;

  assign s_tready = !full;

  sbhp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .data_byte    (s_tdata),
    .record_start (s_tuser),
    .record_last  (s_tlast),
    .push         (push),
    .entry        (push_entry)
  );

  sbhp_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (empty),
    .full       (full)
  );

  sbhp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_kind  (out_kind),
    .out_value (out_value),
    .out_done  (m_tlast),
    .out_trunc (m_tuser)
  );

  assign m_tdata = {3'd0, out_value, out_kind};

endmodule

FILE: src/sbhp_front.sv
// ----------------------------------------------------------------------------
// sbhp_front
// Byte-wise record parser: tracks section and position, classifies each byte
// and pushes one tagged entry for every byte that completes a field.
// ----------------------------------------------------------------------------
module sbhp_front import sbhp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       record_start,
  input  logic       record_last,
  output logic       push,
  output entry_t     entry
);

  logic        active;
  sec_t        section;
  logic [3:0]  byte_position;
  logic        framed_flag;
  outline_t    outline_kind;
  logic [7:0]  held_byte;
  logic [15:0] payload_remaining;

  logic        active_next;
  sec_t        section_next;
  logic [3:0]  byte_position_next;
  logic        framed_flag_next;
  outline_t    outline_kind_next;
  logic [15:0] payload_remaining_next;

  logic        accept;
  logic        act;
  sec_t        sec_cur;
  logic [3:0]  pos_cur;
  logic        framed_cur;
  outline_t    outline_cur;
  logic [15:0] rem_cur;
  logic [15:0] rem_dec;
  logic [15:0] length_word;
  sec_t        tail_sec;

  logic        have;
  logic        done;
  logic        moved;
  kind_t       kind;

  assign accept = in_valid && in_ready;

  // a start byte restarts the record whatever was in progress
  assign act         = record_start || active;
  assign sec_cur     = record_start ? SEC_MAIN : section;
  assign pos_cur     = record_start ? 4'd0 : byte_position;
  assign framed_cur  = record_start ? 1'b0 : framed_flag;
  assign outline_cur = record_start ? OL_NONE : outline_kind;
  assign rem_cur     = record_start ? 16'd0 : payload_remaining;
  assign rem_dec     = rem_cur - 16'd1;
  assign length_word = {held_byte, data_byte};

  always_comb begin
    case (outline_cur)
      OL_OUTLINE:  tail_sec = SEC_OUTLINE;
      OL_SHADOW:   tail_sec = SEC_SHADOW;
      OL_RESERVED: tail_sec = SEC_SKIP;
      default:     tail_sec = SEC_LENGTH;
    endcase
  end

  // byte classification
  always_comb begin
    have  = 1'b0;
    done  = 1'b0;
    moved = 1'b0;
    kind  = K_STYLES;
    case (sec_cur)
      SEC_MAIN: begin
        case (pos_cur)
          4'd0: begin
            have = 1'b1;
            kind = K_STYLES;
          end
          4'd2: begin
            have = 1'b1;
            kind = K_CHAR_COLOUR;
          end
          4'd4: begin
            have = 1'b1;
            kind = K_CHAR_TOP_X;
          end
          4'd5: begin
            have = 1'b1;
            kind = K_CHAR_TOP_Y;
          end
          4'd7: begin
            have = 1'b1;
            kind = K_CHAR_BOT_X;
          end
          4'd8: begin
            have  = 1'b1;
            kind  = K_CHAR_BOT_Y;
            moved = 1'b1;
          end
          default: begin
            have = 1'b0;
          end
        endcase
      end
      SEC_FRAME: begin
        case (pos_cur)
          4'd1: begin
            have = 1'b1;
            kind = K_FRAME_TOP_X;
          end
          4'd2: begin
            have = 1'b1;
            kind = K_FRAME_TOP_Y;
          end
          4'd4: begin
            have = 1'b1;
            kind = K_FRAME_BOT_X;
          end
          4'd5: begin
            have = 1'b1;
            kind = K_FRAME_BOT_Y;
          end
          4'd7: begin
            have  = 1'b1;
            kind  = K_FRAME_COLOUR;
            moved = 1'b1;
          end
          default: begin
            have = 1'b0;
          end
        endcase
      end
      SEC_OUTLINE, SEC_SHADOW: begin
        if (pos_cur == 4'd0) begin
          have = 1'b1;
          kind = (sec_cur == SEC_OUTLINE) ? K_OUTLINE_THICK : K_SHADOW_OFFSETS;
        end else if (pos_cur >= 4'd2) begin
          have  = 1'b1;
          kind  = (sec_cur == SEC_OUTLINE) ? K_OUTLINE_COLOUR : K_SHADOW_COLOUR;
          moved = 1'b1;
        end
      end
      SEC_SKIP: begin
        moved = (pos_cur >= 4'd2);
      end
      SEC_LENGTH: begin
        if (pos_cur >= 4'd1) begin
          have = 1'b1;
          kind = K_LENGTH;
          if (length_word == 16'd0) begin
            done = 1'b1;
          end else begin
            moved = 1'b1;
          end
        end
      end
      SEC_PAYLOAD: begin
        have = 1'b1;
        kind = K_PAYLOAD;
        done = (rem_dec == 16'd0);
      end
      default: begin
        have = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    active_next            = act;
    section_next           = sec_cur;
    byte_position_next     = moved ? 4'd0 : pos_cur + 4'd1;
    framed_flag_next       = framed_cur;
    outline_kind_next      = outline_cur;
    payload_remaining_next = rem_cur;
    case (sec_cur)
      SEC_MAIN: begin
        if (pos_cur == 4'd0) begin
          framed_flag_next  = data_byte[2];
          outline_kind_next = outline_t'(data_byte[1:0]);
        end
        if (moved) begin
          section_next = framed_cur ? SEC_FRAME : tail_sec;
        end
      end
      SEC_FRAME: begin
        if (moved) begin
          section_next = tail_sec;
        end
      end
      SEC_OUTLINE, SEC_SHADOW, SEC_SKIP: begin
        if (moved) begin
          section_next = SEC_LENGTH;
        end
      end
      SEC_LENGTH: begin
        if (pos_cur >= 4'd1) begin
          payload_remaining_next = length_word;
        end
        if (moved) begin
          section_next = SEC_PAYLOAD;
        end
      end
      SEC_PAYLOAD: begin
        payload_remaining_next = rem_dec;
      end
      default: begin
        active_next = 1'b0;
      end
    endcase
    if (done || record_last) begin
      active_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active            <= 1'b0;
      section           <= SEC_MAIN;
      byte_position     <= 4'd0;
      framed_flag       <= 1'b0;
      outline_kind      <= OL_NONE;
      held_byte         <= 8'd0;
      payload_remaining <= 16'd0;
    end else if (accept && act) begin
      active            <= active_next;
      section           <= section_next;
      byte_position     <= byte_position_next;
      framed_flag       <= framed_flag_next;
      outline_kind      <= outline_kind_next;
      held_byte         <= data_byte;
      payload_remaining <= payload_remaining_next;
    end
  end

  // early end replaces whatever field this byte would have finished
  always_comb begin
    push       = accept && act && (have || done || record_last);
    entry.held = held_byte;
    entry.data = data_byte;
    entry.done = done || record_last;
    entry.kind = (!done && record_last) ? K_TRUNC : kind;
  end

`ifndef ASSERT_OFF
  a_done_ends_record: assert property (@(posedge clk) disable iff (rst)
    (push && entry.done) |=> !active)
    else $error("record still active after its final beat");
`endif

endmodule

FILE: src/sbhp_fifo.sv
// ----------------------------------------------------------------------------
// sbhp_fifo
// Short queue of classified entries between the parser and the output stage.
// ----------------------------------------------------------------------------
module sbhp_fifo import sbhp_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output entry_t head,
  output logic   empty,
  output logic   full
);

  entry_t               store [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr;
  logic [FIFO_AW-1:0]   rd_ptr;
  logic [FIFO_CW-1:0]   count;

  assign empty = (count == FIFO_CW'(0));
  assign full  = (count == FIFO_CW'(FIFO_DEPTH));
  assign head  = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + FIFO_CW'(1);
        2'b01:   count <= count - FIFO_CW'(1);
        default: count <= count;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (count <= FIFO_CW'(FIFO_DEPTH)) && !(pop && empty) && !(push && full))
    else $error("queue overrun or underrun");
`endif

endmodule

FILE: src/sbhp_back.sv
// ----------------------------------------------------------------------------
// sbhp_back
// Builds the field value from the queued bytes and holds it in the output
// register until the receiver takes the beat.
// ----------------------------------------------------------------------------
module sbhp_back import sbhp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  entry_t      head,
  input  logic        empty,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output kind_t       out_kind,
  output logic [15:0] out_value,
  output logic        out_done,
  output logic        out_trunc
);

  logic [15:0] value;

  assign pop = !empty && (!out_valid || out_ready);

  always_comb begin
    case (head.kind)
      K_STYLES:
        value = {13'd0, head.data[2:0]};
      K_CHAR_COLOUR, K_FRAME_COLOUR, K_OUTLINE_COLOUR, K_SHADOW_COLOUR, K_LENGTH:
        value = {head.held, head.data};
      K_CHAR_TOP_X, K_CHAR_BOT_X, K_FRAME_TOP_X, K_FRAME_BOT_X:
        value = {4'd0, head.held, head.data[7:4]};
      K_CHAR_TOP_Y, K_CHAR_BOT_Y, K_FRAME_TOP_Y, K_FRAME_BOT_Y:
        value = {4'd0, head.held[3:0], head.data};
      K_OUTLINE_THICK:
        value = {8'd0, head.data & NIBBLE_LO_MASK};
      K_SHADOW_OFFSETS, K_PAYLOAD:
        value = {8'd0, head.data};
      default:
        value = 16'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_kind  <= head.kind;
      out_value <= value;
      out_done  <= head.done;
      out_trunc <= (head.kind == K_TRUNC);
    end
  end

`ifndef ASSERT_OFF
  a_trunc_is_final: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_trunc) |-> (out_done && out_value == 16'd0))
    else $error("truncation beat not marked final or carries a value");

  a_trunc_tag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_trunc == (out_kind == K_TRUNC)))
    else $error("truncation flag disagrees with field tag");
`endif

endmodule
